FILE: rtl/core/linear_diophantine_solver_assert.svh
// Assertion macros for the checker file of the solver.
`ifndef LINEAR_DIOPHANTINE_SOLVER_ASSERT_SVH
`define LINEAR_DIOPHANTINE_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lds: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lds: next-cycle check failed");

`endif

FILE: rtl/core/lds_pkg.sv
package lds_pkg;

  // Default datapath width.
  localparam int unsigned WIDTH_DEF = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_SOLVABLE    = 2'd0,
    ST_NO_SOLUTION = 2'd1,
    ST_BOTH_ZERO   = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    div_final;
    logic    div_step;
    logic    update;
    logic    res_write;
    status_e res_status;
  } lds_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic r0_zero;
    logic r1_zero;
    logic div_last;
    logic rem_zero;
  } lds_sts_t;

endpackage

FILE: rtl/core/linear_diophantine_solver.sv
// Solves a*x + b*y = c for signed 32-bit a, b and c with the extended Euclidean
// algorithm, using quotients and remainders that truncate toward zero. Each beat
// in yields exactly one beat out carrying the status (solvable, no solution, or
// a and b both zero), the gcd as the truncating recursion leaves it (its sign may
// follow the inputs), and the Bezout pair scaled by c/gcd, wrapped to WIDTH bits
// and zero unless the equation is solvable. All work runs through one restoring
// divider that retires one quotient bit per cycle; the products q*s and q*t are
// formed bit by bit alongside it, so no separate multiplier is needed. Each
// Euclid step divides the two latest remainders and then updates remainders and
// coefficients; after the loop, c is divided by the gcd to scale the pair and to
// test solvability, unless a and b are both zero. One item is worked on at a
// time; a finished result sits in an output register, so the next beat may be
// taken while the previous result is still stalled downstream.
module linear_diophantine_solver #(
  parameter int unsigned WIDTH = lds_pkg::WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] target_c_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] divisor_o,
  output logic signed [31:0] coeff_x_o,
  output logic signed [31:0] coeff_y_o
);
  import lds_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  lds_cmd_t cmd;
  lds_sts_t sts;

  // The controller sequences the loop, counts Euclid steps against the bound
  // of 2*WIDTH + 4 and owns both handshakes.
  lds_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the remainder sequence, the coefficients, the shared
  // divider and the result register.
  lds_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_a_i  (value_a_i),
    .value_b_i  (value_b_i),
    .target_c_i (target_c_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .status_o   (status_o),
    .divisor_o  (divisor_o),
    .coeff_x_o  (coeff_x_o),
    .coeff_y_o  (coeff_y_o)
  );

endmodule

FILE: rtl/core/lds_dp.sv
module lds_dp #(
  parameter int unsigned WIDTH = lds_pkg::WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] target_c_i,
  input  lds_pkg::lds_cmd_t  cmd_i,
  output lds_pkg::lds_sts_t  sts_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] divisor_o,
  output logic signed [31:0] coeff_x_o,
  output logic signed [31:0] coeff_y_o
);
  import lds_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  function automatic word_t w_mag(word_t v);
    return v[WIDTH-1] ? word_t'(-v) : v;
  endfunction

  // Remainder sequence and Bezout coefficients.
  word_t r0_q, r1_q, s0_q, s1_q, t0_q, t1_q, c_q;
  // Restoring divider with two Horner accumulators fed by the quotient bits.
  word_t dvd_q, dsr_q, rem_q, ps_q, pt_q;
  logic  qneg_q, nneg_q, fin_q;
  logic [CNT_W-1:0] cnt_q;

  // Result register.
  status_e            status_q;
  logic signed [31:0] divisor_q, coeff_x_q, coeff_y_q;

  word_t          n_sel, d_sel, mul_s, mul_t, rem_nxt, sp_s, sp_t, r_sgn;
  logic [WIDTH:0]   shl;
  logic [WIDTH+1:0] diff;
  logic             qbit;

  always_comb begin
    n_sel   = cmd_i.div_final ? c_q : r0_q;
    d_sel   = cmd_i.div_final ? r0_q : r1_q;
    mul_s   = fin_q ? s0_q : s1_q;
    mul_t   = fin_q ? t0_q : t1_q;
    shl     = {rem_q, dvd_q[WIDTH-1]};
    diff    = {1'b0, shl} - {2'b00, dsr_q};
    qbit    = ~diff[WIDTH+1];
    rem_nxt = qbit ? diff[WIDTH-1:0] : shl[WIDTH-1:0];
    sp_s    = qneg_q ? word_t'(-ps_q) : ps_q;
    sp_t    = qneg_q ? word_t'(-pt_q) : pt_q;
    r_sgn   = nneg_q ? word_t'(-rem_q) : rem_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q <= WIDTH'(value_a_i);
      r1_q <= WIDTH'(value_b_i);
      c_q  <= WIDTH'(target_c_i);
      s0_q <= word_t'(1);
      s1_q <= '0;
      t0_q <= '0;
      t1_q <= word_t'(1);
    end
    if (cmd_i.div_start) begin
      dvd_q  <= w_mag(n_sel);
      dsr_q  <= w_mag(d_sel);
      rem_q  <= '0;
      ps_q   <= '0;
      pt_q   <= '0;
      qneg_q <= n_sel[WIDTH-1] ^ d_sel[WIDTH-1];
      nneg_q <= n_sel[WIDTH-1];
      fin_q  <= cmd_i.div_final;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_nxt;
      ps_q  <= word_t'((ps_q << 1) + (qbit ? mul_s : '0));
      pt_q  <= word_t'((pt_q << 1) + (qbit ? mul_t : '0));
    end
    if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= r_sgn;
      s0_q <= s1_q;
      s1_q <= word_t'(s0_q - sp_s);
      t0_q <= t1_q;
      t1_q <= word_t'(t0_q - sp_t);
    end
    if (cmd_i.res_write) begin
      status_q  <= cmd_i.res_status;
      divisor_q <= 32'(signed'(r0_q));
      if (cmd_i.res_status == ST_SOLVABLE) begin
        coeff_x_q <= 32'(signed'(sp_s));
        coeff_y_q <= 32'(signed'(sp_t));
      end else begin
        coeff_x_q <= '0;
        coeff_y_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.r0_zero  = (r0_q == '0);
  assign sts_o.r1_zero  = (r1_q == '0);
  assign sts_o.div_last = (cnt_q == CNT_W'(WIDTH - 1));
  assign sts_o.rem_zero = (rem_q == '0);

  assign status_o  = status_q;
  assign divisor_o = divisor_q;
  assign coeff_x_o = coeff_x_q;
  assign coeff_y_o = coeff_y_q;

endmodule

FILE: rtl/core/lds_ctrl.sv
module lds_ctrl #(
  parameter int unsigned WIDTH = lds_pkg::WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lds_pkg::lds_cmd_t cmd_o,
  input  lds_pkg::lds_sts_t sts_i
);
  import lds_pkg::*;

  localparam int unsigned ITER_MAX = 2 * WIDTH + 4;
  localparam int unsigned ITER_W   = $clog2(ITER_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_DIV,
    S_UPD,
    S_FDIV,
    S_RES
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] iter_q;
  status_e           res_status_q;
  logic              out_valid_q;
  logic              out_free, loop_go;

  assign out_free = !out_valid_q || !out_stall_i;
  assign loop_go  = !sts_i.r1_zero && (iter_q != ITER_W'(ITER_MAX));

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = res_status_q;
    case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_LOOP: begin
        if (loop_go) begin
          cmd_o.div_start = 1'b1;
        end else if (!sts_i.r0_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_final = 1'b1;
        end
      end
      S_DIV, S_FDIV: cmd_o.div_step = 1'b1;
      S_UPD: cmd_o.update = 1'b1;
      S_RES: begin
        cmd_o.res_write = out_free;
        if (res_status_q == ST_SOLVABLE && !sts_i.rem_zero) begin
          cmd_o.res_status = ST_NO_SOLUTION;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      iter_q       <= '0;
      res_status_q <= ST_SOLVABLE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_o.res_write) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            iter_q  <= '0;
            state_q <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (loop_go) begin
            iter_q  <= iter_q + 1'b1;
            state_q <= S_DIV;
          end else if (!sts_i.r0_zero) begin
            res_status_q <= ST_SOLVABLE;
            state_q      <= S_FDIV;
          end else begin
            res_status_q <= sts_i.r1_zero ? ST_BOTH_ZERO : ST_NO_SOLUTION;
            state_q      <= S_RES;
          end
        end
        S_DIV: begin
          if (sts_i.div_last) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: state_q <= S_LOOP;
        S_FDIV: begin
          if (sts_i.div_last) begin
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/lds_checker.sv
`include "linear_diophantine_solver_assert.svh"

module lds_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic signed [31:0] divisor_o,
  input logic signed [31:0] coeff_x_o,
  input logic signed [31:0] coeff_y_o
);
  import lds_pkg::*;

  // A stalled result beat holds its status.
  `LDS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))

  // The solver takes one item at a time, so an accepted beat closes the input.
  `LDS_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o)

  // Coefficients are zero unless the equation is solvable.
  `LDS_ASSERT_NOW(a_coeff_zero, out_valid_o && status_o != ST_SOLVABLE,
                  coeff_x_o == 32'sd0 && coeff_y_o == 32'sd0)

  // A solvable result always carries a nonzero gcd.
  `LDS_ASSERT_NOW(a_gcd_nonzero, out_valid_o && status_o == ST_SOLVABLE, divisor_o != 32'sd0)

  // Both inputs zero gives a zero gcd.
  `LDS_ASSERT_NOW(a_zero_gcd, out_valid_o && status_o == ST_BOTH_ZERO, divisor_o == 32'sd0)

endmodule

bind linear_diophantine_solver lds_checker u_lds_checker (.*);

FILE: tb/sv/solution_checker.sv
`timescale 1ns / 100ps

module solution_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] target_c_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic signed [31:0] divisor_i,
  input  logic signed [31:0] coeff_x_i,
  input  logic signed [31:0] coeff_y_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 solvable_o,
  output int                 no_solution_o,
  output int                 both_zero_o
);

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    lds_pkg::status_e   status;
    logic signed [31:0] divisor;
    logic signed [31:0] coeff_x;
    logic signed [31:0] coeff_y;
  } solution_t;

  solution_t expected_solutions[$];
  int        mismatches;
  int        results_seen;
  int        solvable_seen;
  int        no_solution_seen;
  int        both_zero_seen;

  // Division that truncates toward zero, done on magnitudes so that the most
  // negative value divided by -1 wraps instead of trapping.
  function automatic void trunc_divmod(input logic [31:0] num, input logic [31:0] den,
                                       output logic [31:0] quo, output logic [31:0] rem);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] quo_mag;
    logic [31:0] rem_mag;
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    quo_mag = num_mag / den_mag;
    rem_mag = num_mag % den_mag;
    quo = (num[31] ^ den[31]) ? -quo_mag : quo_mag;
    rem = num[31] ? -rem_mag : rem_mag;
  endfunction

  function automatic solution_t solve_diophantine(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] c);
    logic [31:0] r0, r1, s0, s1, t0, t1;
    logic [31:0] q, r, k, rem, nxt;
    int          steps;
    solution_t   sol;
    sol.a = a;
    sol.b = b;
    sol.c = c;
    sol.status = lds_pkg::ST_NO_SOLUTION;
    sol.divisor = '0;
    sol.coeff_x = '0;
    sol.coeff_y = '0;
    if (a == 0 && b == 0) begin
      sol.status = lds_pkg::ST_BOTH_ZERO;
      return sol;
    end
    r0 = a;
    r1 = b;
    s0 = 32'd1;
    s1 = 32'd0;
    t0 = 32'd0;
    t1 = 32'd1;
    steps = 0;
    while (r1 != 0 && steps < 68) begin
      trunc_divmod(r0, r1, q, r);
      r0 = r1;
      r1 = r;
      nxt = s0 - q * s1;
      s0 = s1;
      s1 = nxt;
      nxt = t0 - q * t1;
      t0 = t1;
      t1 = nxt;
      steps++;
    end
    sol.divisor = r0;
    if (r0 == 0) return sol;
    trunc_divmod(c, r0, k, rem);
    if (rem != 0) return sol;
    sol.status = lds_pkg::ST_SOLVABLE;
    sol.coeff_x = s0 * k;
    sol.coeff_y = t0 * k;
    return sol;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    solution_t want;
    if (!rst_ni) begin
      expected_solutions.delete();
      mismatches = 0;
      results_seen = 0;
      solvable_seen = 0;
      no_solution_seen = 0;
      both_zero_seen = 0;
    end else begin
      // The result leaves before the beat of this edge is queued, so a result
      // can never be matched against the item accepted in the same cycle.
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_solutions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: status %0d divisor %0d",
                     results_seen, status_i, divisor_i);
        end else begin
          want = expected_solutions.pop_front();
          if (status_i !== want.status || divisor_i !== want.divisor ||
              coeff_x_i !== want.coeff_x || coeff_y_i !== want.coeff_y) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d for a=%0d b=%0d c=%0d", results_seen,
                       want.a, want.b, want.c);
              $display("  expected status %0d divisor %0d x %0d y %0d", want.status,
                       want.divisor, want.coeff_x, want.coeff_y);
              $display("  actual   status %0d divisor %0d x %0d y %0d", status_i,
                       divisor_i, coeff_x_i, coeff_y_i);
            end
          end
          case (want.status)
            lds_pkg::ST_SOLVABLE:    solvable_seen++;
            lds_pkg::ST_NO_SOLUTION: no_solution_seen++;
            default:                 both_zero_seen++;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_solutions.push_back(solve_diophantine(value_a_i, value_b_i, target_c_i));
    end
    fail_count_o  <= mismatches;
    pending_o     <= expected_solutions.size();
    solvable_o    <= solvable_seen;
    no_solution_o <= no_solution_seen;
    both_zero_o   <= both_zero_seen;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the linear Diophantine solver. The checker beside
// the block watches both channels, predicts each result and compares it; this
// module only produces beats, stalls the result channel and decides the outcome.
module tb_top;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

  // All block inputs start at known values; reset is held from time zero.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] value_a = '0;
  logic signed [31:0] value_b = '0;
  logic signed [31:0] target_c = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] divisor;
  logic signed [31:0] coeff_x;
  logic signed [31:0] coeff_y;

  int fail_count;
  int pending;
  int solvable_cnt;
  int no_solution_cnt;
  int both_zero_cnt;
  int beats_sent;
  int burst_left;
  int stall_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  linear_diophantine_solver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_a_i   (value_a),
    .value_b_i   (value_b),
    .target_c_i  (target_c),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .divisor_o   (divisor),
    .coeff_x_o   (coeff_x),
    .coeff_y_o   (coeff_y)
  );

  solution_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .value_a_i     (value_a),
    .value_b_i     (value_b),
    .target_c_i    (target_c),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .divisor_i     (divisor),
    .coeff_x_i     (coeff_x),
    .coeff_y_i     (coeff_y),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .solvable_o    (solvable_cnt),
    .no_solution_o (no_solution_cnt),
    .both_zero_o   (both_zero_cnt)
  );

  // The result channel stalls in runs of random length. Most runs are short,
  // but about one in five is long, so there are long stretches of
  // back-pressure as well as long stretches with none at all.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(0, 6);
    end
  end

  // Sends one beat and returns at the edge where it is taken. The sender works
  // in bursts: valid stays high from one beat to the next within a burst, and
  // drops for a random gap between bursts. A few gaps are long enough to land
  // anywhere inside the block's Euclid loop rather than only at its start.
  task automatic send_beat(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 1500) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    value_a <= a;
    value_b <= b;
    target_c <= c;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Operand with a bias toward the corners: zero, the extremes, small values
  // of either sign, and otherwise any 32-bit pattern.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1: begin
        case ($urandom_range(0, 4))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return 32'hffff_ffff;
          3:       return 32'd1;
          default: return MOST_NEG + 1;
        endcase
      end
      2, 3:    return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] g;
    int          n;
    int          drain;
    beats_sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Both coefficients zero, with and without a target.
    send_beat('0, '0, $urandom);
    send_beat('0, '0, '0);
    // b zero: the divisor is a itself, negative or not, and x carries c/a.
    send_beat(32'd5, '0, 32'd15);
    send_beat(-32'sd7, '0, 32'd21);
    send_beat(MOST_NEG, '0, MOST_NEG);
    send_beat(32'hffff_ffff, '0, 32'hffff_ffff);
    // a zero: the first step swaps the operands.
    send_beat('0, 32'd9, 32'd18);
    send_beat('0, -32'sd9, 32'd18);
    // Most negative value divided by -1 (the quotient wraps) and equal operands: remainder is zero.
    send_beat(MOST_NEG, 32'hffff_ffff, 32'd5);
    send_beat(MOST_NEG, MOST_NEG, MOST_NEG);
    send_beat(32'hffff_ffff, 32'hffff_ffff, MOST_NEG);
    // Extremes against each other.
    send_beat(MOST_POS, MOST_POS, MOST_POS);
    send_beat(MOST_POS, MOST_NEG, MOST_NEG);
    send_beat(MOST_NEG, MOST_POS, 32'hffff_ffff);
    // gcd does not divide c.
    send_beat(32'd6, 32'd4, 32'd3);
    send_beat(MOST_NEG, '0, 32'h4000_0000);
    // Scaled coefficients that reach the edge of the signed 32-bit range.
    send_beat(MOST_POS, MOST_POS - 1, MOST_POS);
    send_beat(32'd1, 32'd1, MOST_POS);
    // Consecutive Fibonacci numbers give the longest remainder chain.
    send_beat(32'd1836311903, 32'd1134903170, 32'd1);
    send_beat(-32'sd1836311903, 32'd1134903170, MOST_NEG);
    send_beat(32'd1134903170, -32'sd1836311903, 32'hdead_beef);
    // Mixed signs, c of zero, and alternating bit patterns.
    send_beat(32'd12, -32'sd18, -32'sd6);
    send_beat($urandom, $urandom, '0);
    send_beat(32'h5555_5555, 32'haaaa_aaaa, $urandom);

    // Random part. A third of the items share a common factor so that the
    // solvable and unsolvable cases both come up often; the rest mix corner
    // operands with fully random patterns, which exercise every input bit.
    for (n = 0; n < 346; n++) begin
      case ($urandom_range(0, 2))
        0: begin
          g = $urandom_range(1, 3000);
          a = g * ($urandom_range(0, 2000) - 1000);
          b = g * ($urandom_range(0, 2000) - 1000);
          c = g * ($urandom_range(0, 200000) - 100000);
          if ($urandom_range(0, 3) == 0) c = c + $urandom_range(1, 2);
        end
        1: begin
          a = pick_operand();
          b = pick_operand();
          c = pick_operand();
        end
        default: begin
          a = $urandom;
          b = $urandom;
          c = $urandom;
        end
      endcase
      send_beat(a, b, c);
    end
    in_valid <= 1'b0;

    // The checker publishes its pending count from a register, so wait for the
    // next edge to let it take in the last beat before trusting the count.
    @(posedge clk);

    // Every beat yields one result, so once nothing is pending the block has
    // gone idle; a short extra wait catches any stray beat after that.
    while (pending != 0) @(posedge clk);
    for (drain = 0; drain < 64; drain++) @(posedge clk);

    $display("run covered %0d beats: %0d solvable, %0d without solution, %0d with a = b = 0",
             beats_sent, solvable_cnt, no_solution_cnt, both_zero_cnt);
    $display("%0d mismatches, %0d results still pending", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // If the run has not finished by the time limit, this ends it as a failure.
  initial begin
    #20_000_000;
    $display("timeout with %0d results pending", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
